// File: src/tcwf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwf_pkg
// Types and constants shared by the time coincidence window filter.
// ----------------------------------------------------------------------------
package tcwf_pkg;

   localparam int ACTION_BITS  = 2;
   localparam int EVENT_BITS   = 32;
   localparam int TAG_BITS     = 16;
   localparam int STORED_BITS  = 9;
   localparam int WIN_BITS     = 32;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DAT_BITS = 32;

   localparam logic [ACTION_BITS-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_TEST  = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_CLEAR = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] REG_WINDOW_LOW  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_WINDOW_HIGH = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_ANTI_MODE   = 2'd2;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic [EVENT_BITS-1:0]  event_time;
      logic [TAG_BITS-1:0]    tag;
   } tcwf_req_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]    tag_echo;
      logic                   selected;
      logic                   load_dropped;
      logic [STORED_BITS-1:0] stored_count;
   } tcwf_rsp_type;

   typedef struct packed {
      logic [WIN_BITS-1:0] window_low;
      logic [WIN_BITS-1:0] window_high;
   } tcwf_win_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } tcwf_tok_type;

endpackage

// File: src/tcwf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwf_cell
// One reference slot: holds a timestamp, checks the passing candidate
// against the window and hands the candidate to the next cell.
// ----------------------------------------------------------------------------
module tcwf_cell #(
   parameter int IDX       = 0,
   parameter int TIME_BITS = 32,
   parameter int CNT_BITS  = 9
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tcwf_pkg::tcwf_tok_type      tok_in,
   input  logic [TIME_BITS-1:0]        time_in,
   output tcwf_pkg::tcwf_tok_type      tok_out,
   output logic [TIME_BITS-1:0]        time_out,
   input  logic                        wr_en,
   input  logic [TIME_BITS-1:0]        wr_time,
   input  logic [CNT_BITS-1:0]         count,
   input  tcwf_pkg::tcwf_win_type      win
);
   import tcwf_pkg::*;

   localparam int CW = (TIME_BITS > WIN_BITS) ? TIME_BITS : WIN_BITS;

   logic [TIME_BITS-1:0] ref_ff;
   logic [TIME_BITS-1:0] time_ff;
   tcwf_tok_type         tok_ff;
   tcwf_tok_type         tok_in_nx;
   logic [TIME_BITS-1:0] diff;
   logic [CW-1:0]        diff_ext;
   logic                 active;
   logic                 hit;

   assign active   = CNT_BITS'(IDX) < count;
   assign diff     = (time_in >= ref_ff) ? (time_in - ref_ff) : (ref_ff - time_in);
   assign diff_ext = CW'(diff);
   assign hit      = active && (diff_ext > CW'(win.window_low))
                     && (diff_ext < CW'(win.window_high));

   always_comb begin
      tok_in_nx.valid = tok_in.valid;
      tok_in_nx.hit   = tok_in.hit | hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      if (wr_en && (count == CNT_BITS'(IDX))) begin
         ref_ff <= wr_time;
      end
   end

   assign tok_out  = tok_ff;
   assign time_out = time_ff;

endmodule

// File: src/tcwf_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwf_chain
// Row of reference cells; a candidate advances one cell per cycle and
// collects the coincidence flag on its way.
// ----------------------------------------------------------------------------
module tcwf_chain #(
   parameter int REF_DEPTH = 256,
   parameter int TIME_BITS = 32,
   parameter int CNT_BITS  = 9
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tcwf_pkg::tcwf_tok_type      tok_in,
   input  logic [TIME_BITS-1:0]        time_in,
   output tcwf_pkg::tcwf_tok_type      tok_out,
   input  logic                        wr_en,
   input  logic [TIME_BITS-1:0]        wr_time,
   input  logic [CNT_BITS-1:0]         count,
   input  tcwf_pkg::tcwf_win_type      win
);
   import tcwf_pkg::*;

   tcwf_tok_type         tok_link  [0:REF_DEPTH];
   logic [TIME_BITS-1:0] time_link [0:REF_DEPTH];

   assign tok_link[0]  = tok_in;
   assign time_link[0] = time_in;

   for (genvar k = 0; k < REF_DEPTH; k++) begin : g_cell
      tcwf_cell #(
         .IDX       (k),
         .TIME_BITS (TIME_BITS),
         .CNT_BITS  (CNT_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_in   (tok_link[k]),
         .time_in  (time_link[k]),
         .tok_out  (tok_link[k+1]),
         .time_out (time_link[k+1]),
         .wr_en    (wr_en),
         .wr_time  (wr_time),
         .count    (count),
         .win      (win)
      );
   end

   assign tok_out = tok_link[REF_DEPTH];

endmodule

// File: src/time_coincidence_window_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_coincidence_window_filter
// Stores reference timestamps and flags candidates whose distance to any
// reference lies strictly inside the programmed window.
//
//   channel  dir  handshake           payload
//   req_     in   req_valid/req_stall tcwf_req_type
//   rsp_     out  rsp_valid/rsp_stall tcwf_rsp_type
//   csr_     in   csr_wr_en           csr_index, csr_wdata
//
// Load, clear and unused actions are answered without a walk; a test keeps the
// input stalled while its candidate walks the cell row, one cell per cycle.
// A result passes through the pending register, then the output register.
// Synchronous reset empties the store; no clearing pass is needed.
// A waiting result holds in a pending slot, so input stalls only when
// both the output and the pending slot are full, or while a test runs.
// ----------------------------------------------------------------------------
module time_coincidence_window_filter #(
   parameter int REF_DEPTH = 256,
   parameter int TIME_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tcwf_pkg::tcwf_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tcwf_pkg::tcwf_rsp_type               rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [tcwf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tcwf_pkg::CSR_DAT_BITS-1:0]    csr_wdata
);
   import tcwf_pkg::*;

   localparam int CNT_BITS = $clog2(REF_DEPTH + 1);
   localparam int CW       = (TIME_BITS > EVENT_BITS) ? TIME_BITS : EVENT_BITS;

   tcwf_win_type          win_ff;
   logic                  anti_ff;
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   count_in;
   logic                  busy_ff;
   logic                  busy_in;
   logic [TAG_BITS-1:0]   tag_ff;
   logic [TAG_BITS-1:0]   tag_in;
   logic                  pend_valid_ff;
   logic                  pend_valid_in;
   tcwf_rsp_type          pend_ff;
   tcwf_rsp_type          pend_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   tcwf_rsp_type          rsp_data_ff;
   tcwf_rsp_type          rsp_data_in;

   logic                  out_free;
   logic                  accept;
   logic                  store_full;
   logic                  wr_en;
   logic [CW-1:0]         time_ext;
   logic [TIME_BITS-1:0]  req_time;
   tcwf_tok_type          launch_tok;
   tcwf_tok_type          exit_tok;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = busy_ff || (pend_valid_ff && !out_free);
   assign accept     = req_valid && !req_stall;
   assign store_full = (count_ff == CNT_BITS'(REF_DEPTH));
   assign time_ext   = CW'(req_data.event_time);
   assign req_time   = time_ext[TIME_BITS-1:0];

   always_comb begin
      launch_tok.valid = accept && (req_data.action == ACT_TEST);
      launch_tok.hit   = 1'b0;
   end

   tcwf_chain #(
      .REF_DEPTH (REF_DEPTH),
      .TIME_BITS (TIME_BITS),
      .CNT_BITS  (CNT_BITS)
   ) u_chain (
      .clock   (clock),
      .reset   (reset),
      .tok_in  (launch_tok),
      .time_in (req_time),
      .tok_out (exit_tok),
      .wr_en   (wr_en),
      .wr_time (req_time),
      .count   (count_ff),
      .win     (win_ff)
   );

   always_comb begin
      count_in      = count_ff;
      busy_in       = busy_ff;
      tag_in        = tag_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_valid_ff && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = pend_ff;
         pend_valid_in = 1'b0;
      end

      if (exit_tok.valid) begin
         busy_in              = 1'b0;
         pend_valid_in        = 1'b1;
         pend_in.tag_echo     = tag_ff;
         pend_in.selected     = anti_ff ^ exit_tok.hit;
         pend_in.load_dropped = 1'b0;
         pend_in.stored_count = STORED_BITS'(count_ff);
      end

      if (accept) begin
         pend_in.tag_echo     = req_data.tag;
         pend_in.selected     = 1'b0;
         pend_in.load_dropped = 1'b0;
         case (req_data.action)
            ACT_LOAD: begin
               if (store_full) begin
                  pend_in.load_dropped = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_BITS'(1);
               end
            end
            ACT_TEST: begin
               busy_in = 1'b1;
               tag_in  = req_data.tag;
            end
            ACT_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
         pend_in.stored_count = STORED_BITS'(count_in);
         if (req_data.action != ACT_TEST) begin
            pend_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         busy_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff      <= tag_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         anti_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_WINDOW_LOW:  win_ff.window_low  <= csr_wdata[WIN_BITS-1:0];
            REG_WINDOW_HIGH: win_ff.window_high <= csr_wdata[WIN_BITS-1:0];
            REG_ANTI_MODE:   anti_ff            <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/tcwf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwf_checker
// Port-level checks for the time coincidence window filter.
// ----------------------------------------------------------------------------
module tcwf_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input tcwf_pkg::tcwf_req_type  req_data,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input tcwf_pkg::tcwf_rsp_type  rsp_data
);
   import tcwf_pkg::*;

   // a test keeps the input closed while the candidate walks the row
   a_test_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.action == ACT_TEST) |=> req_stall)
      else $error("input open right after a test transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.selected && rsp_data.load_dropped))
      else $error("selected and load_dropped both set");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind time_coincidence_window_filter tcwf_checker u_tcwf_checker (.*);
